FILE: hw/rtl/u2da_pkg.sv
// Shared constants and helpers for the unsigned-to-decimal ASCII writer.
`timescale 1ns / 1ps

package u2da_pkg;

  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Number of decimal digits needed for the largest value of the given width.
  // 1233/4096 approximates log10(2) from below, exact over the supported widths.
  function automatic int unsigned num_digits(input int unsigned width);
    num_digits = (width * 1233) / 4096 + 1;
  endfunction

endpackage

FILE: hw/rtl/u2da_dabble.sv
// Bit-serial binary to BCD converter using the shift-and-add-three method.
`timescale 1ns / 1ps

module u2da_dabble #(
  parameter int unsigned VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEFAULT,
  parameter int unsigned NUM_DIGITS  = u2da_pkg::num_digits(VALUE_WIDTH)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0]                 value_i,
  output logic                                   bcd_valid_o,
  input  logic                                   bcd_ready_i,
  output logic [NUM_DIGITS*u2da_pkg::DIGIT_W-1:0] bcd_o
);
  import u2da_pkg::*;

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;

  // Each digit of five or more is corrected by three before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (bcd_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign bcd_valid_o = (state_q == ST_HOLD);
  assign bcd_o       = bcd_q;

endmodule

FILE: hw/rtl/u2da_emit.sv
// Digit shifter that drops leading zeros and sends one ASCII character per word.
`timescale 1ns / 1ps

module u2da_emit #(
  parameter int unsigned NUM_DIGITS = u2da_pkg::num_digits(u2da_pkg::VALUE_WIDTH_DEFAULT)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   bcd_valid_i,
  output logic                                   bcd_ready_o,
  input  logic [NUM_DIGITS*u2da_pkg::DIGIT_W-1:0] bcd_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [u2da_pkg::CHAR_W-1:0]            character_o,
  output logic                                   last_digit_o
);
  import u2da_pkg::*;

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned REM_W = $clog2(NUM_DIGITS + 1);

  logic                 busy_q, busy_d;
  logic                 started_q, started_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [BCD_W-1:0]     dig_q, dig_d;
  logic                 vld_q, vld_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 slot_free;
  logic                 is_last;

  assign top_digit = dig_q[BCD_W-1 -: DIGIT_W];
  assign slot_free = !vld_q || out_ready_i;
  assign is_last   = (rem_q == REM_W'(1));

  always_comb begin
    busy_d    = busy_q;
    started_d = started_q;
    rem_d     = rem_q;
    dig_d     = dig_q;
    vld_d     = vld_q && !out_ready_i;
    char_d    = char_q;
    last_d    = last_q;
    if (!busy_q) begin
      if (bcd_valid_i) begin
        dig_d     = bcd_i;
        rem_d     = REM_W'(NUM_DIGITS);
        started_d = 1'b0;
        busy_d    = 1'b1;
      end
    end else if (!started_q && top_digit == '0 && !is_last) begin
      // Leading zero: drop it without using the output slot.
      dig_d = {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_d = rem_q - REM_W'(1);
    end else if (slot_free) begin
      vld_d     = 1'b1;
      char_d    = ASCII_ZERO + CHAR_W'(top_digit);
      last_d    = is_last;
      started_d = 1'b1;
      dig_d     = {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_d     = rem_q - REM_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      rem_q     <= '0;
      vld_q     <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      started_q <= started_d;
      rem_q     <= rem_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign bcd_ready_o  = !busy_q;
  assign out_valid_o  = vld_q;
  assign character_o  = char_q;
  assign last_digit_o = last_q;

endmodule

FILE: hw/rtl/unsigned_to_decimal_ascii.sv
// Top level of the unsigned-to-decimal ASCII writer.
`timescale 1ns / 1ps

// Usage: an unsigned number is offered on value_i with in_valid_i and is taken
// when in_ready_o is also high. The block answers with one word per decimal
// digit on character_o ('0' to '9'), most significant digit first and without
// leading zeros; last_digit_o marks the final word of the number. Zero gives the
// single word '0'. Conversion is bit-serial: the add-three converter takes the
// number in one bit at a time, most significant bit first, and takes a new number
// only once it has handed its last result to the digit shifter. After acceptance
// the number is converted and its leading zeros are dropped before the first digit
// appears, and further digits follow one per cycle while the receiver keeps
// out_ready_i high. The digit shifter and the converter work independently, so
// the next number is converted while the previous one is still being sent.
// If the receiver stalls, the pending word holds steady; once the converter has
// finished the following number it waits, and in_ready_o stays low. Reset empties
// both stages; nothing is carried from one number to the next.
module unsigned_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u2da_pkg::CHAR_W-1:0] character_o,
  output logic                        last_digit_o
);
  import u2da_pkg::*;

  localparam int unsigned NUM_DIGITS = num_digits(VALUE_WIDTH);

  logic                          bcd_valid;
  logic                          bcd_ready;
  logic [NUM_DIGITS*DIGIT_W-1:0] bcd;

  // Serial converter: one bit of the number enters the BCD register per cycle.
  u2da_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .bcd_valid_o (bcd_valid),
    .bcd_ready_i (bcd_ready),
    .bcd_o       (bcd)
  );

  // Digit shifter: drops leading zeros, then sends one digit per word.
  u2da_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bcd_valid_i  (bcd_valid),
    .bcd_ready_o  (bcd_ready),
    .bcd_i        (bcd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_digit_o (last_digit_o)
  );

endmodule

FILE: tb/tb_unsigned_to_decimal_ascii.sv
// Self-checking testbench for the unsigned-to-decimal ASCII writer.
`timescale 1ns / 1ps

module tb_unsigned_to_decimal_ascii;

  import u2da_pkg::*;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX = 10;
  localparam int unsigned RANDOM_PER_PHASE = 17;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = VALUE_WIDTH + 40;

  // One digit word as the block should produce it.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_digit;
  } digit_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [VALUE_WIDTH-1:0] value_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CHAR_W-1:0]      character_o;
  logic                   last_digit_o;

  // Numbers still to be offered, and digit words still to arrive.
  logic [VALUE_WIDTH-1:0] numbers_to_send[$];
  digit_word_t            expected_digits[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned hold_left;
  int unsigned error_count = 0;

  unsigned_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_digit_o(last_digit_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Works out the decimal spelling of a number and appends its digit words,
  // most significant first, to the store of expected words. Zero falls out of
  // the loop naturally as the single digit '0'.
  function automatic void queue_decimal_digits(input logic [VALUE_WIDTH-1:0] number);
    logic [VALUE_WIDTH-1:0] rest;
    logic [DIGIT_W-1:0]     digit_stack[$];
    digit_word_t            word;
    rest = number;
    do begin
      digit_stack.push_front(DIGIT_W'(rest % RADIX));
      rest = rest / RADIX;
    end while (rest != 0);
    foreach (digit_stack[k]) begin
      word.character  = ASCII_ZERO + CHAR_W'(digit_stack[k]);
      word.last_digit = (k == digit_stack.size() - 1);
      expected_digits.push_back(word);
    end
  endfunction

  // Random numbers spread over all digit counts, not only over the bits:
  // a plain 32-bit draw gives ten digits about three times in four.
  function automatic logic [VALUE_WIDTH-1:0] random_number();
    longint unsigned low;
    longint unsigned high;
    int unsigned     digits;
    digits = $urandom_range(10, 1);
    low = 1;
    repeat (digits - 1) low = low * RADIX;
    high = low * RADIX - 1;
    if (digits == 1) low = 0;
    if (high > 64'hFFFF_FFFF) high = 64'hFFFF_FFFF;
    case ($urandom_range(3))
      0: return $urandom;
      1: return VALUE_WIDTH'(low);
      2: return VALUE_WIDTH'(high);
      default: return VALUE_WIDTH'(low + ({$urandom, $urandom} % (high - low + 1)));
    endcase
  endfunction

  // Driver: a number is taken off the queue whenever the input slot is free and
  // the sender is not idling. Accepted numbers are turned into expected words
  // on the spot, so the store always runs ahead of the block's output.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        queue_decimal_digits(value_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (numbers_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          value_i    <= numbers_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps pushing
  // numbers in while the output is blocked and the block has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: every accepted word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digits.size() == 0) begin
        $error("Unexpected digit word: character %0d last_digit %0b",
               character_o, last_digit_o);
        error_count++;
      end else begin
        digit_word_t want;
        want = expected_digits.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, character_o);
          error_count++;
        end
        if (last_digit_o !== want.last_digit) begin
          $error("last_digit: expected %0b, got %0b", want.last_digit, last_digit_o);
          error_count++;
        end
      end
    end
  end

  // Waits until every queued number has gone in and every digit has come out.
  task automatic wait_until_drained();
    while (numbers_to_send.size() > 0 || in_valid_i || expected_digits.size() > 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sequencer: all control changes happen on the falling edge, well away from
  // the edge at which the driver and the monitor sample.
  initial begin
    int unsigned idle_settings[4][2];
    idle_settings = '{'{0, 0}, '{84, 0}, '{0, 84}, '{27, 27}};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed numbers: zero, single digits, several boundaries between digit
    // counts, and the top of the range with all bits set.
    numbers_to_send.push_back(32'd0);
    numbers_to_send.push_back(32'd1);
    numbers_to_send.push_back(32'd9);
    numbers_to_send.push_back(32'd10);
    numbers_to_send.push_back(32'd99);
    numbers_to_send.push_back(32'd100);
    numbers_to_send.push_back(32'd1000);
    numbers_to_send.push_back(32'd99999);
    numbers_to_send.push_back(32'd1000000);
    numbers_to_send.push_back(32'd9999999);
    numbers_to_send.push_back(32'd100000000);
    numbers_to_send.push_back(32'd999999999);
    numbers_to_send.push_back(32'd1000000000);
    numbers_to_send.push_back(32'd1234567890);
    numbers_to_send.push_back(32'h8000_0000);
    numbers_to_send.push_back(32'h7FFF_FFFF);
    numbers_to_send.push_back(32'hFFFF_FFFE);
    numbers_to_send.push_back(32'hFFFF_FFFF);
    numbers_to_send.push_back(32'hAAAA_AAAA);
    numbers_to_send.push_back(32'h5555_5555);
    wait_until_drained();

    // Random numbers under each idling pattern in turn.
    foreach (idle_settings[p]) begin
      sender_idle_pct    = idle_settings[p][0];
      receiver_stall_pct = idle_settings[p][1];
      repeat (RANDOM_PER_PHASE) numbers_to_send.push_back(random_number());
      wait_until_drained();
    end

    // Back pressure: the receiver is held off for a long stretch while the
    // sender offers numbers back to back.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (12) numbers_to_send.push_back(random_number());
    hold_request = 1'b1;
    @(negedge clk_i);
    hold_request = 1'b0;
    wait_until_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_digits.size() > 0) begin
      $error("%0d digit words never arrived", expected_digits.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, set far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
